// File: sv/s2d_pkg.sv
// Package for the signed integer to decimal ASCII converter.
// Holds widths, character codes, the cell operation codes and the state type.
// No dependencies.
package s2d_pkg;

    localparam int VALUE_WIDTH = 32;
    // Decimal digits needed for any VALUE_WIDTH-bit magnitude (log10(2) ~ 0.30103).
    localparam int NUM_DIGITS  = (VALUE_WIDTH * 30103) / 100000 + 1;
    localparam int BIT_CNT_W   = $clog2(VALUE_WIDTH + 1);
    localparam int DIG_CNT_W   = $clog2(NUM_DIGITS + 1);
    localparam int COUNT_W     = 4;
    localparam int CHAR_W      = 8;
    localparam int DIGIT_W     = 4;

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'd48;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'd45;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'd57;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_CLEAR,
        CELL_CONVERT,
        CELL_SHIFT
    } cell_op_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CONVERT,
        S_SKIP,
        S_SIGN,
        S_DIGITS
    } state_t;

endpackage

// File: sv/signed_int_to_decimal_ascii.sv
// Top level of the signed integer to decimal ASCII converter.
// Holds the control sequencer, the chain of BCD cells and the output register.
// Depends on s2d_pkg and s2d_bcd_cell.
//
// Usage:
//   Input channel (value, in_valid, in_ready) takes one two's complement
//   integer per item. Output channel (char_code, is_last, char_count,
//   out_valid, out_ready) gives the decimal text one character per item:
//   a '-' for negative values, then the digits with no leading zeros.
//   The last character has is_last set and char_count holding the total
//   number of characters; char_count is 0 on the others.
//   Sequence: the item is accepted in the idle state, then the chain of digit
//   cells runs VALUE_WIDTH (32) shift-and-add-3 steps, then one step per
//   leading zero dropped and one more to fix the count, then one step per
//   character. Dropped zeros and digits always add to NUM_DIGITS (10). The
//   next item is accepted once the last character has entered the output
//   register.
//   A stalled receiver holds the output register and the sequencer waits;
//   nothing is dropped. Reset empties the output register and returns the
//   sequencer to idle.
module signed_int_to_decimal_ascii
    import s2d_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic signed [VALUE_WIDTH-1:0] value,
    input  logic                          in_valid,
    output logic                          in_ready,
    output logic        [CHAR_W-1:0]      char_code,
    output logic                          is_last,
    output logic        [COUNT_W-1:0]     char_count,
    output logic                          out_valid,
    input  logic                          out_ready
);

    state_t                 state_reg, state_next;
    logic [VALUE_WIDTH-1:0] mag_reg, mag_next;
    logic                   neg_reg, neg_next;
    logic [BIT_CNT_W-1:0]   bit_cnt_reg, bit_cnt_next;
    logic [DIG_CNT_W-1:0]   dig_cnt_reg, dig_cnt_next;
    logic [COUNT_W-1:0]     total_reg, total_next;

    logic                   out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0]      char_code_reg, char_code_next;
    logic                   is_last_reg, is_last_next;
    logic [COUNT_W-1:0]     char_count_reg, char_count_next;

    cell_op_t               op;
    logic [NUM_DIGITS-1:0]  carry;
    logic [DIGIT_W-1:0]     digit [NUM_DIGITS];
    logic [DIGIT_W-1:0]     top_digit;
    logic [VALUE_WIDTH-1:0] value_u;
    logic                   out_free;
    logic                   last_digit;

    assign value_u    = unsigned'(value);
    assign top_digit  = digit[NUM_DIGITS-1];
    assign out_free   = !out_valid_reg || out_ready;
    assign last_digit = (dig_cnt_reg == DIG_CNT_W'(1));
    assign in_ready   = (state_reg == S_IDLE);

    genvar g;
    generate
        for (g = 0; g < NUM_DIGITS; g++)
        begin : g_cell
            logic               cell_bit_in;
            logic [DIGIT_W-1:0] cell_digit_in;
            if (g == 0)
            begin : g_low
                assign cell_bit_in   = mag_reg[VALUE_WIDTH-1];
                assign cell_digit_in = '0;
            end
            else
            begin : g_mid
                assign cell_bit_in   = carry[g-1];
                assign cell_digit_in = digit[g-1];
            end
            s2d_bcd_cell u_cell (
                .clk      (clk),
                .op       (op),
                .bit_in   (cell_bit_in),
                .digit_in (cell_digit_in),
                .bit_out  (carry[g]),
                .digit    (digit[g])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg        <= mag_next;
        neg_reg        <= neg_next;
        bit_cnt_reg    <= bit_cnt_next;
        dig_cnt_reg    <= dig_cnt_next;
        total_reg      <= total_next;
        char_code_reg  <= char_code_next;
        is_last_reg    <= is_last_next;
        char_count_reg <= char_count_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        mag_next        = mag_reg;
        neg_next        = neg_reg;
        bit_cnt_next    = bit_cnt_reg;
        dig_cnt_next    = dig_cnt_reg;
        total_next      = total_reg;
        op              = CELL_HOLD;
        out_valid_next  = out_valid_reg && !out_ready;
        char_code_next  = char_code_reg;
        is_last_next    = is_last_reg;
        char_count_next = char_count_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    neg_next     = value_u[VALUE_WIDTH-1];
                    mag_next     = value_u[VALUE_WIDTH-1] ? (~value_u + 1'b1) : value_u;
                    bit_cnt_next = BIT_CNT_W'(VALUE_WIDTH);
                    op           = CELL_CLEAR;
                    state_next   = S_CONVERT;
                end
            end
            S_CONVERT:
            begin
                op           = CELL_CONVERT;
                mag_next     = {mag_reg[VALUE_WIDTH-2:0], 1'b0};
                bit_cnt_next = bit_cnt_reg - 1'b1;
                if (bit_cnt_reg == BIT_CNT_W'(1))
                begin
                    dig_cnt_next = DIG_CNT_W'(NUM_DIGITS);
                    state_next   = S_SKIP;
                end
            end
            S_SKIP:
            begin
                // drop leading zeros, keep at least one digit
                if (top_digit == '0 && !last_digit)
                begin
                    op           = CELL_SHIFT;
                    dig_cnt_next = dig_cnt_reg - 1'b1;
                end
                else
                begin
                    total_next = COUNT_W'(dig_cnt_reg + DIG_CNT_W'(neg_reg));
                    state_next = neg_reg ? S_SIGN : S_DIGITS;
                end
            end
            S_SIGN:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    char_code_next  = CHAR_MINUS;
                    is_last_next    = 1'b0;
                    char_count_next = '0;
                    state_next      = S_DIGITS;
                end
            end
            S_DIGITS:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    char_code_next  = CHAR_ZERO + CHAR_W'(top_digit);
                    is_last_next    = last_digit;
                    char_count_next = last_digit ? total_reg : '0;
                    op              = CELL_SHIFT;
                    dig_cnt_next    = dig_cnt_reg - 1'b1;
                    if (last_digit)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid  = out_valid_reg;
    assign char_code  = char_code_reg;
    assign is_last    = is_last_reg;
    assign char_count = char_count_reg;

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CONVERT |-> !carry[NUM_DIGITS-1])
        else $error("digit chain overflow");

    a_start_convert: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> state_reg == S_CONVERT)
        else $error("accepted item did not start conversion");

    a_last_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_last |-> char_count != '0)
        else $error("last character without count");

    a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (char_code == CHAR_MINUS) ||
                      (char_code >= CHAR_ZERO && char_code <= CHAR_NINE))
        else $error("character out of range");

endmodule

// File: sv/s2d_bcd_cell.sv
// One BCD digit cell of the shift-and-add-3 chain.
// Clears, holds, adjusts and shifts in a bit, or takes its lower neighbor's digit.
// Depends on s2d_pkg.
module s2d_bcd_cell
    import s2d_pkg::*;
(
    input  logic               clk,
    input  cell_op_t           op,
    input  logic               bit_in,
    input  logic [DIGIT_W-1:0] digit_in,
    output logic               bit_out,
    output logic [DIGIT_W-1:0] digit
);

    logic [DIGIT_W-1:0] digit_reg;
    logic [DIGIT_W-1:0] digit_next;
    logic [DIGIT_W-1:0] adj;

    always_comb
    begin
        adj = (digit_reg >= 4'd5) ? digit_reg + 4'd3 : digit_reg;
        unique case (op)
            CELL_HOLD:    digit_next = digit_reg;
            CELL_CLEAR:   digit_next = '0;
            CELL_CONVERT: digit_next = {adj[DIGIT_W-2:0], bit_in};
            CELL_SHIFT:   digit_next = digit_in;
            default:      digit_next = digit_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        digit_reg <= digit_next;
    end

    assign bit_out = adj[DIGIT_W-1];
    assign digit   = digit_reg;

endmodule
